/* design/puvbb_pkg.sv */
package puvbb_pkg;

	localparam int COORD_BITS_DEF       = 32;
	localparam int UV_FRACTION_BITS_DEF = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAS_X,
		ST_MEAS_Z,
		ST_SETUP,
		ST_CLASSIFY,
		ST_DIV
	} puvbb_state_t;

	// per-axis outcome of the map classification
	typedef enum logic [1:0] {
		CLS_DIV,
		CLS_HALF,
		CLS_ZERO,
		CLS_ONE
	} puvbb_cls_t;

endpackage

/* design/planar_uv_from_bounding_box_top.sv */
// Planar UV mapping from an XZ bounding box.
// Input channel (in_valid/in_ready) carries one vertex per transaction: opcode,
// first_vertex, coord_x and coord_z (signed fixed point). Opcode 0 measures:
// the box grows over X and Z, or restarts at the vertex when first_vertex is
// set. Opcode 1 maps: one result transaction with tex_u and tex_v (unsigned
// Q1.UV_FRACTION_BITS) leaves on the output channel (out_valid/out_ready).
// A measure transaction passes through accept, X compare and Z compare and
// yields no result. A map transaction goes from accept through a step that
// forms ranges and offsets and a step that classifies the special cases;
// then two restoring dividers produce one quotient bit per cycle each, while
// the last step waits if the output register is full and not read. The block
// takes no new transaction until the bit-serial division has finished.
// The next transaction is accepted as soon as the block returns to idle, even
// while a result still waits in the output register. If the receiver stalls,
// the result holds in the output register; a following map item finishes its
// division and then holds its last step until the register frees up.
// Reset clears the box to the single point (0, 0) and empties the output.
module planar_uv_from_bounding_box_top
	import puvbb_pkg::*;
#(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int UV_FRACTION_BITS = UV_FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic                               first_vertex,
	input  logic signed [COORD_BITS-1:0]       coord_x,
	input  logic signed [COORD_BITS-1:0]       coord_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [UV_FRACTION_BITS:0]   tex_u,
	output logic        [UV_FRACTION_BITS:0]   tex_v
);

	localparam int CNT_W = $clog2(UV_FRACTION_BITS);

	puvbb_state_t state_q, state_d;

	// latched transaction
	logic                         first_q;
	logic signed [COORD_BITS-1:0] x_q, z_q;

	// bounding box
	logic signed [COORD_BITS-1:0] lx_q, gx_q, lz_q, gz_q;

	// ranges and offsets, one bit wider than the coordinates
	logic signed [COORD_BITS:0] rng_x_q, off_x_q, rng_z_q, off_z_q;
	logic signed [COORD_BITS:0] ofs_rng_x, ofs_rng_z;

	puvbb_cls_t cls_x_q, cls_z_q;
	puvbb_cls_t cls_x_d, cls_z_d;

	// bit-serial divider state
	logic [COORD_BITS-1:0]       rem_x_q, rem_z_q;
	logic [UV_FRACTION_BITS-1:0] quo_x_q, quo_z_q;
	logic [CNT_W-1:0]            cnt_q;

	logic [COORD_BITS:0]   rem_x_sh, rem_z_sh;
	logic [COORD_BITS+1:0] sub_x, sub_z;
	logic                  bit_x, bit_z;
	logic [COORD_BITS-1:0] rem_x_d, rem_z_d;
	logic [UV_FRACTION_BITS-1:0] quo_x_d, quo_z_d;

	logic [UV_FRACTION_BITS:0] res_u, res_v;
	logic [UV_FRACTION_BITS:0] tex_u_q, tex_v_q;
	logic                      out_valid_q;

	logic div_last, div_go, load_out, in_fire;

	localparam logic [UV_FRACTION_BITS:0] UV_HALF =
		{2'b01, {(UV_FRACTION_BITS-1){1'b0}}};
	localparam logic [UV_FRACTION_BITS:0] UV_ONE =
		{1'b1, {UV_FRACTION_BITS{1'b0}}};

	// ---------------------------------------------------------------- control
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		in_fire  = in_valid && in_ready;
		div_last = (cnt_q == CNT_W'(UV_FRACTION_BITS - 1));
		// hold the last step while the output register is full and not being read
		div_go   = (state_q == ST_DIV) && !(div_last && out_valid_q && !out_ready);
		load_out = div_go && div_last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = opcode ? ST_SETUP : ST_MEAS_X;
			end
			ST_MEAS_X:   state_d = ST_MEAS_Z;
			ST_MEAS_Z:   state_d = ST_IDLE;
			ST_SETUP:    state_d = ST_CLASSIFY;
			ST_CLASSIFY: state_d = ST_DIV;
			ST_DIV: begin
				if (load_out) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------- input latch
	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_q <= first_vertex;
			x_q     <= coord_x;
			z_q     <= coord_z;
		end
	end

	// -------------------------------------------------------- box tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= '0;
			gx_q <= '0;
			lz_q <= '0;
			gz_q <= '0;
		end else begin
			if (state_q == ST_MEAS_X) begin
				if (first_q) begin
					lx_q <= x_q;
					gx_q <= x_q;
				end else begin
					if (x_q < lx_q) lx_q <= x_q;
					if (x_q > gx_q) gx_q <= x_q;
				end
			end
			if (state_q == ST_MEAS_Z) begin
				if (first_q) begin
					lz_q <= z_q;
					gz_q <= z_q;
				end else begin
					if (z_q < lz_q) lz_q <= z_q;
					if (z_q > gz_q) gz_q <= z_q;
				end
			end
		end
	end

	// ------------------------------------------------ ranges and classification
	always_comb begin
		ofs_rng_x = off_x_q - rng_x_q;
		ofs_rng_z = off_z_q - rng_z_q;

		if (rng_x_q <= 0)       cls_x_d = CLS_HALF;
		else if (off_x_q <= 0)  cls_x_d = CLS_ZERO;
		else if (!ofs_rng_x[COORD_BITS]) cls_x_d = CLS_ONE;
		else                    cls_x_d = CLS_DIV;

		if (rng_z_q <= 0)       cls_z_d = CLS_HALF;
		else if (off_z_q <= 0)  cls_z_d = CLS_ZERO;
		else if (!ofs_rng_z[COORD_BITS]) cls_z_d = CLS_ONE;
		else                    cls_z_d = CLS_DIV;
	end

	// ----------------------------------------------------- divider datapath
	always_comb begin
		rem_x_sh = {rem_x_q, 1'b0};
		rem_z_sh = {rem_z_q, 1'b0};
		sub_x    = {1'b0, rem_x_sh} - {2'b00, rng_x_q[COORD_BITS-1:0]};
		sub_z    = {1'b0, rem_z_sh} - {2'b00, rng_z_q[COORD_BITS-1:0]};
		bit_x    = ~sub_x[COORD_BITS+1];
		bit_z    = ~sub_z[COORD_BITS+1];
		rem_x_d  = bit_x ? sub_x[COORD_BITS-1:0] : rem_x_sh[COORD_BITS-1:0];
		rem_z_d  = bit_z ? sub_z[COORD_BITS-1:0] : rem_z_sh[COORD_BITS-1:0];
		quo_x_d  = {quo_x_q[UV_FRACTION_BITS-2:0], bit_x};
		quo_z_d  = {quo_z_q[UV_FRACTION_BITS-2:0], bit_z};
	end

	always_comb begin
		case (cls_x_q)
			CLS_HALF: res_u = UV_HALF;
			CLS_ZERO: res_u = '0;
			CLS_ONE:  res_u = UV_ONE;
			default:  res_u = {1'b0, quo_x_d};
		endcase
		case (cls_z_q)
			CLS_HALF: res_v = UV_HALF;
			CLS_ZERO: res_v = '0;
			CLS_ONE:  res_v = UV_ONE;
			default:  res_v = {1'b0, quo_z_d};
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			rng_x_q <= {gx_q[COORD_BITS-1], gx_q} - {lx_q[COORD_BITS-1], lx_q};
			off_x_q <= {x_q[COORD_BITS-1], x_q}   - {lx_q[COORD_BITS-1], lx_q};
			rng_z_q <= {gz_q[COORD_BITS-1], gz_q} - {lz_q[COORD_BITS-1], lz_q};
			off_z_q <= {z_q[COORD_BITS-1], z_q}   - {lz_q[COORD_BITS-1], lz_q};
		end
		if (state_q == ST_CLASSIFY) begin
			cls_x_q <= cls_x_d;
			cls_z_q <= cls_z_d;
			rem_x_q <= off_x_q[COORD_BITS-1:0];
			rem_z_q <= off_z_q[COORD_BITS-1:0];
			quo_x_q <= '0;
			quo_z_q <= '0;
		end else if (div_go) begin
			// advance both quotients by one bit
			rem_x_q <= rem_x_d;
			rem_z_q <= rem_z_d;
			quo_x_q <= quo_x_d;
			quo_z_q <= quo_z_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_CLASSIFY) begin
			cnt_q <= '0;
		end else if (div_go && !div_last) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			tex_u_q <= res_u;
			tex_v_q <= res_v;
		end
	end

	assign out_valid = out_valid_q;
	assign tex_u     = tex_u_q;
	assign tex_v     = tex_v_q;

endmodule
